// ===== hw/rtl/fpfa_pkg.sv =====
// shared types and constants for the fixed partition fit allocator
// no dependencies; used by fixed_partition_fit_allocator_core

package fpfa_pkg;

   // default table shape
   localparam int PARTITIONS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   // fixed field widths on the ports
   localparam int OP_BITS     = 2;
   localparam int SLOT_BITS   = 4;
   localparam int AMOUNT_BITS = 16;
   localparam int MODE_BITS   = 2;
   localparam int COUNT_BITS  = 5;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 5;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [MODE_BITS-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } fit_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FIT_MODE   = 1'b0,
      CSR_PART_COUNT = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/fixed_partition_fit_allocator_core.sv =====
// fixed partition allocator: size table, used flags and a one-entry-per-cycle scan
// depends on fpfa_pkg for widths, codes and the sequencer state type

// channel  dir  handshake             payload
// req      in   req_tvalid/req_tready tuser[1:0] operation; tdata[3:0] slot, [19:4] amount
// rsp      out  rsp_tvalid/rsp_tready tuser[0] granted; tdata[3:0] chosen_slot, [19:4] size
// csr      in   csr_valid/csr_ready   csr_index register, csr_data value (always ready)
//
// load and free-all give no result
// an allocate scans limit entries (limit = min(partition_count, PARTITIONS)) in the
// single compare unit, one table entry per cycle, then drains; limit 0 goes to finish
// the result waits in the output register; a new item is taken meanwhile, and a
// later allocate holds in its finish step until the output register is free
// synchronous active-high reset; no clearing pass, sizes are covered by valid bits

module fixed_partition_fit_allocator_core #(
   parameter int PARTITIONS = fpfa_pkg::PARTITIONS_DEF,
   parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fpfa_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // slot, amount, zero pad
   input  logic [fpfa_pkg::OP_BITS-1:0]         req_tuser,  // operation
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fpfa_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // chosen_slot, chosen_size, pad
   output logic                                 rsp_tuser,  // granted
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fpfa_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [fpfa_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int IDX_BITS = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int CNT_BITS = $clog2(PARTITIONS + 1);

   // request unpacking
   logic [fpfa_pkg::SLOT_BITS-1:0]   req_slot;
   logic [fpfa_pkg::AMOUNT_BITS-1:0] req_amount;
   logic                             req_fire;
   logic                             rsp_fire;

   assign req_slot   = req_tdata[fpfa_pkg::SLOT_BITS-1:0];
   assign req_amount = req_tdata[fpfa_pkg::SLOT_BITS +: fpfa_pkg::AMOUNT_BITS];
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // configuration registers
   logic [fpfa_pkg::MODE_BITS-1:0]  fit_mode_ff;
   logic [fpfa_pkg::COUNT_BITS-1:0] part_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= '0;
         part_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fpfa_pkg::CSR_FIT_MODE:   fit_mode_ff   <= csr_data[fpfa_pkg::MODE_BITS-1:0];
            fpfa_pkg::CSR_PART_COUNT: part_count_ff <= csr_data[fpfa_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   fpfa_pkg::state_type state_ff, state_in;
   logic [CNT_BITS-1:0] scan_ff;
   logic [CNT_BITS-1:0] limit_ff;
   logic [CNT_BITS-1:0] limit_in;
   logic                last_issue;
   logic                is_alloc;
   logic                scan_issue;
   logic                rsp_load;

   assign is_alloc   = (req_tuser == fpfa_pkg::OP_ALLOC);
   assign limit_in   = (32'(part_count_ff) > PARTITIONS) ? CNT_BITS'(PARTITIONS)
                                                          : CNT_BITS'(part_count_ff);
   assign last_issue = (CNT_BITS'(scan_ff + 1'b1) == limit_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fpfa_pkg::ST_IDLE: begin
            if (req_fire && is_alloc) begin
               state_in = (limit_in == '0) ? fpfa_pkg::ST_FINISH : fpfa_pkg::ST_SCAN;
            end
         end
         fpfa_pkg::ST_SCAN: begin
            if (last_issue) begin
               state_in = fpfa_pkg::ST_DRAIN;
            end
         end
         fpfa_pkg::ST_DRAIN: begin
            state_in = fpfa_pkg::ST_FINISH;
         end
         fpfa_pkg::ST_FINISH: begin
            if (!rsp_tvalid || rsp_tready) begin
               state_in = fpfa_pkg::ST_IDLE;
            end
         end
         default: state_in = fpfa_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      scan_issue = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         fpfa_pkg::ST_IDLE:   req_tready = 1'b1;
         fpfa_pkg::ST_SCAN:   scan_issue = 1'b1;
         fpfa_pkg::ST_DRAIN:  ;
         fpfa_pkg::ST_FINISH: rsp_load   = !rsp_tvalid || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpfa_pkg::ST_IDLE;
         scan_ff  <= '0;
         limit_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire && is_alloc) begin
            scan_ff  <= '0;
            limit_ff <= limit_in;
         end else if (scan_issue) begin
            scan_ff  <= CNT_BITS'(scan_ff + 1'b1);
         end
      end
   end

   // partition size table, one write and one registered read per cycle
   logic [SIZE_BITS-1:0]  size_mem [PARTITIONS];
   logic [PARTITIONS-1:0] size_valid_ff;
   logic [PARTITIONS-1:0] used_ff;
   logic                  load_hit;
   logic [IDX_BITS-1:0]   load_idx;
   logic [IDX_BITS-1:0]   scan_idx;

   assign load_hit = req_fire && (req_tuser == fpfa_pkg::OP_LOAD) &&
                     (32'(req_slot) < PARTITIONS);
   assign load_idx = IDX_BITS'(req_slot);
   assign scan_idx = scan_ff[IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (load_hit) begin
         size_mem[load_idx] <= SIZE_BITS'(req_amount);
      end
   end

   // read stage for the entry being examined
   logic [SIZE_BITS-1:0] rd_size_ff;
   logic                 rd_size_ok_ff;
   logic                 rd_used_ff;
   logic [IDX_BITS-1:0]  stage_idx_ff;
   logic                 stage_valid_ff;

   always_ff @(posedge clock) begin
      if (scan_issue) begin
         rd_size_ff    <= size_mem[scan_idx];
         rd_size_ok_ff <= size_valid_ff[scan_idx];
         rd_used_ff    <= used_ff[scan_idx];
         stage_idx_ff  <= scan_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= scan_issue;
      end
   end

   // shared compare unit: larger than the request, then beats the current pick
   logic [SIZE_BITS-1:0] amount_ff;
   logic [SIZE_BITS-1:0] stage_size;
   logic                 candidate;
   logic                 better;
   logic                 found_ff;
   logic [IDX_BITS-1:0]  pick_idx_ff;
   logic [SIZE_BITS-1:0] pick_size_ff;

   assign stage_size = rd_size_ok_ff ? rd_size_ff : '0;
   assign candidate  = stage_valid_ff && !rd_used_ff && (stage_size > amount_ff);

   // same request on every entry, so comparing sizes orders the leftovers
   always_comb begin
      case (fit_mode_ff)
         fpfa_pkg::FIT_BEST:  better = stage_size < pick_size_ff;
         fpfa_pkg::FIT_WORST: better = stage_size > pick_size_ff;
         default:             better = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire && is_alloc) begin
         amount_ff <= SIZE_BITS'(req_amount);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (req_fire && is_alloc) begin
         found_ff <= 1'b0;
      end else if (candidate && (!found_ff || better)) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (candidate && (!found_ff || better)) begin
         pick_idx_ff  <= stage_idx_ff;
         pick_size_ff <= stage_size;
      end
   end

   // valid bits for sizes and used flags
   always_ff @(posedge clock) begin
      if (reset) begin
         size_valid_ff <= '0;
         used_ff       <= '0;
      end else begin
         if (load_hit) begin
            size_valid_ff[load_idx] <= 1'b1;
         end
         if (req_fire && (req_tuser == fpfa_pkg::OP_CLEAR)) begin
            used_ff <= '0;
         end else if (rsp_load && found_ff) begin
            used_ff[pick_idx_ff] <= 1'b1;
         end
      end
   end

   // output register
   logic                               rsp_valid_ff;
   logic                               rsp_granted_ff;
   logic [fpfa_pkg::SLOT_BITS-1:0]     rsp_slot_ff;
   logic [fpfa_pkg::AMOUNT_BITS-1:0]   rsp_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_granted_ff <= found_ff;
         rsp_slot_ff    <= found_ff ? fpfa_pkg::SLOT_BITS'(pick_idx_ff) : '0;
         rsp_size_ff    <= found_ff ? fpfa_pkg::AMOUNT_BITS'(pick_size_ff) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = {{(fpfa_pkg::RSP_DATA_BITS - fpfa_pkg::SLOT_BITS
                          - fpfa_pkg::AMOUNT_BITS){1'b0}}, rsp_size_ff, rsp_slot_ff};

`ifndef NO_ASSERTIONS
   // an allocate holds off further requests while it scans
   a_alloc_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_alloc) |=> !req_tready)
      else $error("request accepted during an allocation");

   // a grant leaves its partition marked used
   a_grant_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && found_ff) |=> used_ff[$past(pick_idx_ff)])
      else $error("granted partition not marked used");

   // a refusal carries no slot and no size
   a_refusal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("refusal with non-zero payload");

   // entries are examined only while scanning or draining
   a_stage_state: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |-> (state_ff == fpfa_pkg::ST_SCAN || state_ff == fpfa_pkg::ST_DRAIN))
      else $error("entry examined outside a scan");
`endif

endmodule
